// ----- rtl/chfa_pkg.sv -----
// ----------------------------------------------------------------------------
// chfa_pkg
// Shared types and codes for the contiguous hole-fit allocator: operation
// and status codes, sequencer states, the shared unit's operations and the
// table control group.
// ----------------------------------------------------------------------------
package chfa_pkg;

   // default configuration of the block
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int ADDR_BITS_DEF  = 16;
   localparam int TAG_BITS_DEF   = 8;

   // width of the memory size register and of its reset value
   localparam int          CSR_BITS       = 16;
   localparam logic [15:0] MEM_SIZE_RESET = 16'hFFFF;

   // operation codes
   localparam logic [2:0] FUNC_FIRST_FIT = 3'd0;
   localparam logic [2:0] FUNC_BEST_FIT  = 3'd1;
   localparam logic [2:0] FUNC_WORST_FIT = 3'd2;
   localparam logic [2:0] FUNC_FREE      = 3'd3;
   localparam logic [2:0] FUNC_COMPACT   = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // shared add/subtract unit
   typedef enum logic {
      ALU_SUB,
      ALU_ADD
   } alu_op_type;

   // table port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } table_ctl_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHK_FREE,
      ST_CHK_FULL,
      ST_SCAN_RD,
      ST_SCAN_LEN,
      ST_SCAN_FIT,
      ST_SCAN_CMP,
      ST_SCAN_NEXT,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_INS_UPD,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_FREE_UPD,
      ST_CMP_RD,
      ST_CMP_LEN,
      ST_CMP_WR,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/chfa_alu.sv -----
// ----------------------------------------------------------------------------
// chfa_alu
// Shared add/subtract unit. Every length, fit test, size compare and
// address sum of the allocator goes through this one unit.
// ----------------------------------------------------------------------------
module chfa_alu #(
   parameter int WIDTH = chfa_pkg::ADDR_BITS_DEF
) (
   input  chfa_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   output logic [WIDTH-1:0]     result,
   output logic                 borrow
);
   import chfa_pkg::*;

   logic [WIDTH:0] full;

   // one wide add or subtract, borrow flags a < b on subtract
   always_comb begin
      case (op)
         ALU_ADD: full = {1'b0, a} + {1'b0, b};
         ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default: full = {1'b0, a} - {1'b0, b};
      endcase
   end

   assign result = full[WIDTH-1:0];
   assign borrow = (op == ALU_SUB) && full[WIDTH];

endmodule

// ----- rtl/chfa_table.sv -----
// ----------------------------------------------------------------------------
// chfa_table
// Block table memory: start, end and tag of each allocated block, one
// write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chfa_table #(
   parameter int MAX_BLOCKS = chfa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = chfa_pkg::ADDR_BITS_DEF,
   parameter int TAG_BITS   = chfa_pkg::TAG_BITS_DEF,
   localparam int IDX_BITS  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  logic                    clock,
   input  chfa_pkg::table_ctl_type ctl,
   input  logic [IDX_BITS-1:0]     wr_addr,
   input  logic [ADDR_BITS-1:0]    wr_start,
   input  logic [ADDR_BITS-1:0]    wr_end,
   input  logic [TAG_BITS-1:0]     wr_tag,
   input  logic [IDX_BITS-1:0]     rd_addr,
   output logic [ADDR_BITS-1:0]    rd_start,
   output logic [ADDR_BITS-1:0]    rd_end,
   output logic [TAG_BITS-1:0]     rd_tag
);
   import chfa_pkg::*;

   logic [ADDR_BITS-1:0] start_mem [MAX_BLOCKS];
   logic [ADDR_BITS-1:0] end_mem   [MAX_BLOCKS];
   logic [TAG_BITS-1:0]  tag_mem   [MAX_BLOCKS];

   logic [ADDR_BITS-1:0] rd_start_ff;
   logic [ADDR_BITS-1:0] rd_end_ff;
   logic [TAG_BITS-1:0]  rd_tag_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         start_mem[wr_addr] <= wr_start;
         end_mem[wr_addr]   <= wr_end;
         tag_mem[wr_addr]   <= wr_tag;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_start_ff <= start_mem[rd_addr];
         rd_end_ff   <= end_mem[rd_addr];
         rd_tag_ff   <= tag_mem[rd_addr];
      end
   end

   assign rd_start = rd_start_ff;
   assign rd_end   = rd_end_ff;
   assign rd_tag   = rd_tag_ff;

endmodule

// ----- rtl/chfa_seq.sv -----
// ----------------------------------------------------------------------------
// chfa_seq
// Sequencer of the allocator: scans the holes, shifts table entries for
// insert and removal, compacts, and keeps count, free units and memory size.
// ----------------------------------------------------------------------------
module chfa_seq #(
   parameter int MAX_BLOCKS = chfa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = chfa_pkg::ADDR_BITS_DEF,
   parameter int TAG_BITS   = chfa_pkg::TAG_BITS_DEF,
   localparam int IDX_BITS  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int CNT_BITS  = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   // request side
   input  logic                     req_take,
   input  logic [2:0]               req_func,
   input  logic [ADDR_BITS-1:0]     req_request_size,
   input  logic [TAG_BITS-1:0]      req_block_tag,
   output logic                     idle,
   // memory size register
   input  logic                     csr_wen,
   input  logic [chfa_pkg::CSR_BITS-1:0] csr_wdata,
   // result side
   input  logic                     hold,
   output logic                     done,
   output logic [1:0]               res_status,
   output logic [ADDR_BITS-1:0]     res_placed_at,
   output logic [ADDR_BITS-1:0]     res_freed_units,
   output logic [CNT_BITS-1:0]      res_blocks_in_use,
   output logic [ADDR_BITS-1:0]     res_units_left,
   // shared unit
   output chfa_pkg::alu_op_type     alu_op,
   output logic [ADDR_BITS-1:0]     alu_a,
   output logic [ADDR_BITS-1:0]     alu_b,
   input  logic [ADDR_BITS-1:0]     alu_result,
   input  logic                     alu_borrow,
   // table
   output chfa_pkg::table_ctl_type  tbl_ctl,
   output logic [IDX_BITS-1:0]      tbl_wr_addr,
   output logic [ADDR_BITS-1:0]     tbl_wr_start,
   output logic [ADDR_BITS-1:0]     tbl_wr_end,
   output logic [TAG_BITS-1:0]      tbl_wr_tag,
   output logic [IDX_BITS-1:0]      tbl_rd_addr,
   input  logic [ADDR_BITS-1:0]     tbl_rd_start,
   input  logic [ADDR_BITS-1:0]     tbl_rd_end,
   input  logic [TAG_BITS-1:0]      tbl_rd_tag
);
   import chfa_pkg::*;

   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_BLOCKS);
   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [ADDR_BITS-1:0] free_ff, free_in;
   logic [ADDR_BITS-1:0] memsize_ff, memsize_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [CNT_BITS-1:0]  i_ff, i_in;
   logic [2:0]           func_ff, func_in;
   logic [ADDR_BITS-1:0] size_ff, size_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [ADDR_BITS-1:0] prev_end_ff, prev_end_in;
   logic [ADDR_BITS-1:0] hole_end_ff, hole_end_in;
   logic [ADDR_BITS-1:0] len_ff, len_in;
   logic                 found_ff, found_in;
   logic [CNT_BITS-1:0]  pick_ff, pick_in;
   logic [ADDR_BITS-1:0] pick_len_ff, pick_len_in;
   logic [ADDR_BITS-1:0] pick_lo_ff, pick_lo_in;
   logic [ADDR_BITS-1:0] cursor_ff, cursor_in;
   logic [1:0]           status_ff, status_in;
   logic [ADDR_BITS-1:0] placed_ff, placed_in;
   logic [ADDR_BITS-1:0] freed_ff, freed_in;

   logic                 k_in_table;
   logic                 tag_match;
   logic [ADDR_BITS-1:0] clamped;
   logic [CNT_BITS-1:0]  i_dec;
   logic [CNT_BITS-1:0]  i_inc;
   logic                 is_alloc;

   assign k_in_table = (k_ff < count_ff);
   assign tag_match  = (tbl_rd_tag == tag_ff);
   assign clamped    = alu_borrow ? '0 : alu_result;
   assign i_dec      = i_ff - CNT_ONE;
   assign i_inc      = i_ff + CNT_ONE;
   assign is_alloc   = (req_func == FUNC_FIRST_FIT) || (req_func == FUNC_BEST_FIT) ||
                       (req_func == FUNC_WORST_FIT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (is_alloc) begin
                  state_in = ST_CHK_FREE;
               end else if (req_func == FUNC_FREE) begin
                  state_in = ST_FREE_RD;
               end else if (req_func == FUNC_COMPACT) begin
                  state_in = ST_CMP_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CHK_FREE:  state_in = alu_borrow ? ST_DONE : ST_CHK_FULL;
         ST_CHK_FULL:  state_in = (count_ff >= CNT_MAX) ? ST_DONE : ST_SCAN_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_LEN;
         ST_SCAN_LEN:  state_in = ST_SCAN_FIT;
         ST_SCAN_FIT: begin
            if (alu_borrow) begin
               state_in = ST_SCAN_NEXT;
            end else if (!found_ff) begin
               state_in = (func_ff == FUNC_FIRST_FIT) ? ST_INS_RD : ST_SCAN_NEXT;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP:  state_in = ST_SCAN_NEXT;
         ST_SCAN_NEXT: begin
            if (k_in_table) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = found_ff ? ST_INS_RD : ST_DONE;
            end
         end
         ST_INS_RD:    state_in = (i_ff == pick_ff) ? ST_INS_PUT : ST_INS_WR;
         ST_INS_WR:    state_in = ST_INS_RD;
         ST_INS_PUT:   state_in = ST_INS_UPD;
         ST_INS_UPD:   state_in = ST_DONE;
         ST_FREE_RD:   state_in = k_in_table ? ST_FREE_CHK : ST_DONE;
         ST_FREE_CHK:  state_in = tag_match ? ST_DEL_RD : ST_FREE_RD;
         ST_DEL_RD:    state_in = (i_inc >= count_ff) ? ST_FREE_UPD : ST_DEL_WR;
         ST_DEL_WR:    state_in = ST_DEL_RD;
         ST_FREE_UPD:  state_in = ST_DONE;
         ST_CMP_RD:    state_in = k_in_table ? ST_CMP_LEN : ST_DONE;
         ST_CMP_LEN:   state_in = ST_CMP_WR;
         ST_CMP_WR:    state_in = ST_CMP_RD;
         ST_DONE:      state_in = hold ? ST_DONE : ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // shared unit and table port control
   always_comb begin
      alu_op       = ALU_SUB;
      alu_a        = '0;
      alu_b        = '0;
      tbl_ctl      = '0;
      tbl_rd_addr  = k_ff[IDX_BITS-1:0];
      tbl_wr_addr  = i_ff[IDX_BITS-1:0];
      tbl_wr_start = tbl_rd_start;
      tbl_wr_end   = tbl_rd_end;
      tbl_wr_tag   = tbl_rd_tag;
      case (state_ff)
         ST_CHK_FREE: begin
            alu_a = free_ff;
            alu_b = size_ff;
         end
         ST_SCAN_RD: begin
            tbl_ctl.rd_en = k_in_table;
         end
         ST_SCAN_LEN: begin
            alu_a = k_in_table ? tbl_rd_start : memsize_ff;
            alu_b = prev_end_ff;
         end
         ST_SCAN_FIT: begin
            alu_a = len_ff;
            alu_b = size_ff;
         end
         ST_SCAN_CMP: begin
            // best fit: len < pick_len, worst fit: pick_len < len
            alu_a = (func_ff == FUNC_BEST_FIT) ? len_ff : pick_len_ff;
            alu_b = (func_ff == FUNC_BEST_FIT) ? pick_len_ff : len_ff;
         end
         ST_INS_RD: begin
            tbl_ctl.rd_en = (i_ff != pick_ff);
            tbl_rd_addr   = i_dec[IDX_BITS-1:0];
         end
         ST_INS_WR: begin
            tbl_ctl.wr_en = 1'b1;
         end
         ST_INS_PUT: begin
            alu_op        = ALU_ADD;
            alu_a         = pick_lo_ff;
            alu_b         = size_ff;
            tbl_ctl.wr_en = 1'b1;
            tbl_wr_addr   = pick_ff[IDX_BITS-1:0];
            tbl_wr_start  = pick_lo_ff;
            tbl_wr_end    = alu_result;
            tbl_wr_tag    = tag_ff;
         end
         ST_INS_UPD: begin
            alu_a = free_ff;
            alu_b = size_ff;
         end
         ST_FREE_RD: begin
            tbl_ctl.rd_en = k_in_table;
         end
         ST_FREE_CHK: begin
            alu_a = tbl_rd_end;
            alu_b = tbl_rd_start;
         end
         ST_DEL_RD: begin
            tbl_ctl.rd_en = (i_inc < count_ff);
            tbl_rd_addr   = i_inc[IDX_BITS-1:0];
         end
         ST_DEL_WR: begin
            tbl_ctl.wr_en = 1'b1;
         end
         ST_FREE_UPD: begin
            alu_op = ALU_ADD;
            alu_a  = free_ff;
            alu_b  = len_ff;
         end
         ST_CMP_RD: begin
            tbl_ctl.rd_en = k_in_table;
         end
         ST_CMP_LEN: begin
            alu_a = tbl_rd_end;
            alu_b = tbl_rd_start;
         end
         ST_CMP_WR: begin
            alu_op        = ALU_ADD;
            alu_a         = cursor_ff;
            alu_b         = len_ff;
            tbl_ctl.wr_en = 1'b1;
            tbl_wr_addr   = k_ff[IDX_BITS-1:0];
            tbl_wr_start  = cursor_ff;
            tbl_wr_end    = alu_result;
         end
         default: begin
            alu_op = ALU_SUB;
         end
      endcase
   end

   // datapath register updates
   always_comb begin
      count_in    = count_ff;
      free_in     = free_ff;
      memsize_in  = memsize_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      func_in     = func_ff;
      size_in     = size_ff;
      tag_in      = tag_ff;
      prev_end_in = prev_end_ff;
      hole_end_in = hole_end_ff;
      len_in      = len_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      pick_len_in = pick_len_ff;
      pick_lo_in  = pick_lo_ff;
      cursor_in   = cursor_ff;
      status_in   = status_ff;
      placed_in   = placed_ff;
      freed_in    = freed_ff;
      case (state_ff)
         ST_IDLE: begin
            // size write empties the table
            if (csr_wen) begin
               memsize_in = ADDR_BITS'(csr_wdata);
               free_in    = ADDR_BITS'(csr_wdata);
               count_in   = '0;
            end
            if (req_take) begin
               func_in   = req_func;
               size_in   = req_request_size;
               tag_in    = req_block_tag;
               k_in      = '0;
               cursor_in = '0;
               status_in = STATUS_DONE;
               placed_in = '0;
               freed_in  = '0;
            end
         end
         ST_CHK_FREE: begin
            if (alu_borrow) begin
               status_in = STATUS_NO_SPACE;
            end
         end
         ST_CHK_FULL: begin
            prev_end_in = '0;
            found_in    = 1'b0;
            if (count_ff >= CNT_MAX) begin
               status_in = STATUS_FULL;
            end
         end
         ST_SCAN_LEN: begin
            len_in      = clamped;
            hole_end_in = tbl_rd_end;
         end
         ST_SCAN_FIT: begin
            if (!alu_borrow && !found_ff) begin
               found_in    = 1'b1;
               pick_in     = k_ff;
               pick_len_in = len_ff;
               pick_lo_in  = prev_end_ff;
               i_in        = count_ff;
            end
         end
         ST_SCAN_CMP: begin
            if (alu_borrow) begin
               pick_in     = k_ff;
               pick_len_in = len_ff;
               pick_lo_in  = prev_end_ff;
            end
         end
         ST_SCAN_NEXT: begin
            prev_end_in = hole_end_ff;
            i_in        = count_ff;
            if (k_in_table) begin
               k_in = k_ff + CNT_ONE;
            end else if (!found_ff) begin
               status_in = STATUS_NO_SPACE;
            end
         end
         ST_INS_WR: begin
            i_in = i_dec;
         end
         ST_INS_UPD: begin
            free_in   = alu_result;
            count_in  = count_ff + CNT_ONE;
            placed_in = pick_lo_ff;
         end
         ST_FREE_RD: begin
            if (!k_in_table) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         ST_FREE_CHK: begin
            if (tag_match) begin
               len_in = clamped;
               i_in   = k_ff;
            end else begin
               k_in = k_ff + CNT_ONE;
            end
         end
         ST_DEL_WR: begin
            i_in = i_inc;
         end
         ST_FREE_UPD: begin
            free_in  = alu_result;
            count_in = count_ff - CNT_ONE;
            freed_in = len_ff;
         end
         ST_CMP_LEN: begin
            len_in = clamped;
         end
         ST_CMP_WR: begin
            cursor_in = alu_result;
            k_in      = k_ff + CNT_ONE;
         end
         default: begin
            len_in = len_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         free_ff    <= ADDR_BITS'(MEM_SIZE_RESET);
         memsize_ff <= ADDR_BITS'(MEM_SIZE_RESET);
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         free_ff    <= free_in;
         memsize_ff <= memsize_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      i_ff        <= i_in;
      func_ff     <= func_in;
      size_ff     <= size_in;
      tag_ff      <= tag_in;
      prev_end_ff <= prev_end_in;
      hole_end_ff <= hole_end_in;
      len_ff      <= len_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pick_len_ff <= pick_len_in;
      pick_lo_ff  <= pick_lo_in;
      cursor_ff   <= cursor_in;
      status_ff   <= status_in;
      placed_ff   <= placed_in;
      freed_ff    <= freed_in;
   end

   assign idle              = (state_ff == ST_IDLE);
   assign done              = (state_ff == ST_DONE) && !hold;
   assign res_status        = status_ff;
   assign res_placed_at     = placed_ff;
   assign res_freed_units   = freed_ff;
   assign res_blocks_in_use = count_ff;
   assign res_units_left    = free_ff;

endmodule

// ----- rtl/contiguous_hole_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_hole_fit_allocator
// Address-ordered block table with first, best and worst fit allocation,
// free by tag and compaction, run by a sequencer over one shared adder.
// ----------------------------------------------------------------------------
// Sequence, accept to response valid: allocation checks free units and the
//   table count, scans the holes, then shifts entries up to insert; free searches
//   entries by tag, then shifts later entries down; compact rewrites each entry.
// Throughput: one transaction at a time on the single adder and table read
//   port; the next request is taken from the cycle the response goes valid.
// Reset: synchronous; empties the table, memory size and free units 65535.
module contiguous_hole_fit_allocator #(
   parameter int MAX_BLOCKS = chfa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = chfa_pkg::ADDR_BITS_DEF,
   parameter int TAG_BITS   = chfa_pkg::TAG_BITS_DEF,
   localparam int IDX_BITS  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int CNT_BITS  = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // memory size register
   input  logic                          csr_wen,
   input  logic [chfa_pkg::CSR_BITS-1:0] csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_func,
   input  logic [ADDR_BITS-1:0]          req_request_size,
   input  logic [TAG_BITS-1:0]           req_block_tag,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [ADDR_BITS-1:0]          rsp_placed_at,
   output logic [ADDR_BITS-1:0]          rsp_freed_units,
   output logic [CNT_BITS-1:0]           rsp_blocks_in_use,
   output logic [ADDR_BITS-1:0]          rsp_units_left
);
   import chfa_pkg::*;

   logic                 idle;
   logic                 done;
   logic                 hold;
   logic [1:0]           res_status;
   logic [ADDR_BITS-1:0] res_placed_at;
   logic [ADDR_BITS-1:0] res_freed_units;
   logic [CNT_BITS-1:0]  res_blocks_in_use;
   logic [ADDR_BITS-1:0] res_units_left;

   alu_op_type           alu_op;
   logic [ADDR_BITS-1:0] alu_a;
   logic [ADDR_BITS-1:0] alu_b;
   logic [ADDR_BITS-1:0] alu_result;
   logic                 alu_borrow;

   table_ctl_type        tbl_ctl;
   logic [IDX_BITS-1:0]  tbl_wr_addr;
   logic [ADDR_BITS-1:0] tbl_wr_start;
   logic [ADDR_BITS-1:0] tbl_wr_end;
   logic [TAG_BITS-1:0]  tbl_wr_tag;
   logic [IDX_BITS-1:0]  tbl_rd_addr;
   logic [ADDR_BITS-1:0] tbl_rd_start;
   logic [ADDR_BITS-1:0] tbl_rd_end;
   logic [TAG_BITS-1:0]  tbl_rd_tag;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_placed_ff;
   logic [ADDR_BITS-1:0] rsp_freed_ff;
   logic [CNT_BITS-1:0]  rsp_blocks_ff;
   logic [ADDR_BITS-1:0] rsp_units_ff;

   // request handshake
   assign req_stall = !idle;
   assign hold      = rsp_valid_ff && rsp_stall;

   chfa_seq #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_take          (req_valid && !req_stall),
      .req_func          (req_func),
      .req_request_size  (req_request_size),
      .req_block_tag     (req_block_tag),
      .idle              (idle),
      .csr_wen           (csr_wen),
      .csr_wdata         (csr_wdata),
      .hold              (hold),
      .done              (done),
      .res_status        (res_status),
      .res_placed_at     (res_placed_at),
      .res_freed_units   (res_freed_units),
      .res_blocks_in_use (res_blocks_in_use),
      .res_units_left    (res_units_left),
      .alu_op            (alu_op),
      .alu_a             (alu_a),
      .alu_b             (alu_b),
      .alu_result        (alu_result),
      .alu_borrow        (alu_borrow),
      .tbl_ctl           (tbl_ctl),
      .tbl_wr_addr       (tbl_wr_addr),
      .tbl_wr_start      (tbl_wr_start),
      .tbl_wr_end        (tbl_wr_end),
      .tbl_wr_tag        (tbl_wr_tag),
      .tbl_rd_addr       (tbl_rd_addr),
      .tbl_rd_start      (tbl_rd_start),
      .tbl_rd_end        (tbl_rd_end),
      .tbl_rd_tag        (tbl_rd_tag)
   );

   chfa_alu #(
      .WIDTH (ADDR_BITS)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .borrow (alu_borrow)
   );

   chfa_table #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_table (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .wr_addr  (tbl_wr_addr),
      .wr_start (tbl_wr_start),
      .wr_end   (tbl_wr_end),
      .wr_tag   (tbl_wr_tag),
      .rd_addr  (tbl_rd_addr),
      .rd_start (tbl_rd_start),
      .rd_end   (tbl_rd_end),
      .rd_tag   (tbl_rd_tag)
   );

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded when a transaction finishes
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= res_status;
         rsp_placed_ff <= res_placed_at;
         rsp_freed_ff  <= res_freed_units;
         rsp_blocks_ff <= res_blocks_in_use;
         rsp_units_ff  <= res_units_left;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_placed_at     = rsp_placed_ff;
   assign rsp_freed_units   = rsp_freed_ff;
   assign rsp_blocks_in_use = rsp_blocks_ff;
   assign rsp_units_left    = rsp_units_ff;

endmodule
